// ----- hdl/lmp_pkg.sv -----
// Shared constants and types for the layer-mapping MIMO precoder.
// Used by the multiply-accumulate pipe and the top level.
package lmp_pkg;

   localparam int MAX_LAYERS  = 4;
   localparam int MAX_PORTS   = 4;
   localparam int WEIGHT_BITS = 16;

   localparam int IN_LAYERS   = 4;
   localparam int USED_LAYERS = (MAX_LAYERS < IN_LAYERS) ? MAX_LAYERS : IN_LAYERS;
   localparam int USED_PORTS  = (MAX_PORTS < 4) ? MAX_PORTS : 4;

   localparam int SAMP_W      = 8;
   localparam int IN_W_BITS   = 16;
   localparam int IDX_W       = 4;
   localparam int CNT_W       = 3;
   localparam int PORT_W      = 2;
   localparam int RES_W       = 27;
   localparam int PROD_W      = SAMP_W + WEIGHT_BITS;
   localparam int TERM_W      = PROD_W + 1;

   localparam int RAM_ADDR_W  = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
   localparam int LAYER_W     = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;

   typedef struct packed {
      logic signed [SAMP_W-1:0] re;
      logic signed [SAMP_W-1:0] im;
   } csamp_type;

   typedef struct packed {
      logic signed [WEIGHT_BITS-1:0] re;
      logic signed [WEIGHT_BITS-1:0] im;
   } cweight_type;

   localparam int WEIGHT_W = $bits(cweight_type);

   // per-result control that rides along the pipe
   typedef struct packed {
      logic              last;
      logic [PORT_W-1:0] port;
      logic [CNT_W-1:0]  nl;
   } tag_type;

endpackage

// ----- hdl/lmp_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies; read-first when both ports hit the same address.
module lmp_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 4,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/lmp_mac.sv -----
// Complex multiply and layer sum for one port result, plus the output register.
// Depends on lmp_pkg; fed by the weight read stage of the top level.
module lmp_mac
   import lmp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_valid,
   input  tag_type                  rd_tag,
   input  csamp_type                rd_samples [IN_LAYERS],
   input  cweight_type              rd_weights [USED_LAYERS],
   output logic                     rd_adv,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [PORT_W-1:0]        rsp_port_index,
   output logic signed [RES_W-1:0]  rsp_port_re,
   output logic signed [RES_W-1:0]  rsp_port_im,
   output logic                     rsp_last_port
);

   logic                     mul_valid_ff, mul_valid_in;
   tag_type                  mul_tag_ff;
   logic signed [TERM_W-1:0] term_re_ff [USED_LAYERS];
   logic signed [TERM_W-1:0] term_im_ff [USED_LAYERS];
   logic signed [TERM_W-1:0] term_re_in [USED_LAYERS];
   logic signed [TERM_W-1:0] term_im_in [USED_LAYERS];

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [PORT_W-1:0]        rsp_port_ff;
   logic                     rsp_last_ff;
   logic signed [RES_W-1:0]  rsp_re_ff, rsp_im_ff;
   logic signed [RES_W-1:0]  sum_re_in, sum_im_in;

   logic                     adv_out, adv_mul;

   assign adv_out = !rsp_valid_ff || !rsp_stall;
   assign adv_mul = !mul_valid_ff || adv_out;
   assign rd_adv  = adv_mul;

   for (genvar l = 0; l < USED_LAYERS; l++) begin : g_lane
      logic signed [PROD_W-1:0] rr, ii, ri, ir;
      logic                     used;
      assign rr   = rd_samples[l].re * rd_weights[l].re;
      assign ii   = rd_samples[l].im * rd_weights[l].im;
      assign ri   = rd_samples[l].re * rd_weights[l].im;
      assign ir   = rd_samples[l].im * rd_weights[l].re;
      assign used = CNT_W'(l) < rd_tag.nl;
      assign term_re_in[l] = used ? (TERM_W'(rr) - TERM_W'(ii)) : '0;
      assign term_im_in[l] = used ? (TERM_W'(ri) + TERM_W'(ir)) : '0;
   end

   always_comb begin
      sum_re_in = '0;
      sum_im_in = '0;
      for (int l = 0; l < USED_LAYERS; l++) begin
         sum_re_in = sum_re_in + RES_W'(term_re_ff[l]);
         sum_im_in = sum_im_in + RES_W'(term_im_ff[l]);
      end
   end

   assign mul_valid_in = adv_mul ? rd_valid : mul_valid_ff;
   assign rsp_valid_in = adv_out ? mul_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (adv_mul) begin
         mul_tag_ff <= rd_tag;
         term_re_ff <= term_re_in;
         term_im_ff <= term_im_in;
      end
      if (adv_out) begin
         rsp_port_ff <= mul_tag_ff.port;
         rsp_last_ff <= mul_tag_ff.last;
         rsp_re_ff   <= sum_re_in;
         rsp_im_ff   <= sum_im_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_port_index = rsp_port_ff;
   assign rsp_port_re    = rsp_re_ff;
   assign rsp_port_im    = rsp_im_ff;
   assign rsp_last_port  = rsp_last_ff;

   a_mul_hold: assert property (@(posedge clock) disable iff (reset)
      (mul_valid_ff && !adv_out) |=> (mul_valid_ff && $stable(mul_tag_ff)))
      else $error("multiply stage lost its beat while blocked");

   a_mul_to_out: assert property (@(posedge clock) disable iff (reset)
      (mul_valid_ff && adv_out) |=> rsp_valid_ff)
      else $error("multiply stage beat did not reach the output");

   a_rd_to_mul: assert property (@(posedge clock) disable iff (reset)
      (rd_valid && rd_adv) |=> mul_valid_ff)
      else $error("read stage beat did not reach the multiply stage");

endmodule

// ----- hdl/layer_map_mimo_precoder_top.sv -----
// Precoder top level: APB registers, port sequencer, per-layer weight RAMs, MAC pipe.
// A sample beat passes the sequencer, read and multiply stages and output register,
// giving one result per cycle unless the output stalls; it holds the sequencer for
// its active ports (1 to 4), one weight-RAM read of all layers per port; loads do not.
// Reset clears the pipe and sets both registers to 1; weights are undefined until loaded.
module layer_map_mimo_precoder_top
   import lmp_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_action,
   input  logic [IDX_W-1:0]            req_weight_index,
   input  logic signed [IN_W_BITS-1:0] req_weight_re,
   input  logic signed [IN_W_BITS-1:0] req_weight_im,
   input  logic signed [SAMP_W-1:0]    req_layer0_re,
   input  logic signed [SAMP_W-1:0]    req_layer0_im,
   input  logic signed [SAMP_W-1:0]    req_layer1_re,
   input  logic signed [SAMP_W-1:0]    req_layer1_im,
   input  logic signed [SAMP_W-1:0]    req_layer2_re,
   input  logic signed [SAMP_W-1:0]    req_layer2_im,
   input  logic signed [SAMP_W-1:0]    req_layer3_re,
   input  logic signed [SAMP_W-1:0]    req_layer3_im,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [PORT_W-1:0]           rsp_port_index,
   output logic signed [RES_W-1:0]     rsp_port_re,
   output logic signed [RES_W-1:0]     rsp_port_im,
   output logic                        rsp_last_port,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [2:0]                  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   localparam logic REG_LAYERS = 1'b0;
   localparam logic REG_PORTS  = 1'b1;
   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_SAMPLE = 1'b1;

   typedef struct packed {
      logic                  valid;
      logic [RAM_ADDR_W-1:0] port;
      logic [LAYER_W-1:0]    layer;
   } slot_type;

   function automatic slot_type slot_decode(input logic [IDX_W-1:0] idx);
      slot_type s;
      s = '0;
      for (int p = 0; p < MAX_PORTS; p++) begin
         for (int l = 0; l < MAX_LAYERS; l++) begin
            if (int'(idx) == p * MAX_LAYERS + l) begin
               s.valid = 1'b1;
               s.port  = RAM_ADDR_W'(p);
               s.layer = LAYER_W'(l);
            end
         end
      end
      return s;
   endfunction

   function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                    input int hi);
      logic [CNT_W-1:0] r;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (v > CNT_W'(hi)) begin
         r = CNT_W'(hi);
      end else begin
         r = v;
      end
      return r;
   endfunction

   // configuration registers
   logic [CNT_W-1:0] cfg_layers_ff, cfg_ports_ff;
   logic             csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_layers_ff <= CNT_W'(1);
         cfg_ports_ff  <= CNT_W'(1);
      end else if (csr_write) begin
         unique case (paddr[2])
            REG_LAYERS: cfg_layers_ff <= pwdata[CNT_W-1:0];
            REG_PORTS:  cfg_ports_ff  <= pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_LAYERS: prdata = 32'(cfg_layers_ff);
         REG_PORTS:  prdata = 32'(cfg_ports_ff);
         default:    prdata = '0;
      endcase
   end

   // input beat
   csamp_type in_samples [IN_LAYERS];
   logic      req_accept, take, rd_adv;
   slot_type  slot;

   assign in_samples[0] = {req_layer0_re, req_layer0_im};
   assign in_samples[1] = {req_layer1_re, req_layer1_im};
   assign in_samples[2] = {req_layer2_re, req_layer2_im};
   assign in_samples[3] = {req_layer3_re, req_layer3_im};

   assign req_stall  = !take;
   assign req_accept = req_valid && take;
   assign slot       = slot_decode(req_weight_index);

   // port sequencer
   logic              iss_valid_ff, iss_valid_in;
   logic [PORT_W-1:0] iss_port_ff, iss_port_in;
   logic [CNT_W-1:0]  iss_np_ff, iss_nl_ff;
   csamp_type         iss_samples_ff [IN_LAYERS];
   logic              iss_last;
   logic              start;

   assign iss_last = (CNT_W'(iss_port_ff) + CNT_W'(1)) == iss_np_ff;
   assign take     = !iss_valid_ff || (iss_last && rd_adv);
   assign start    = req_accept && (req_action == ACT_SAMPLE);

   always_comb begin
      iss_valid_in = iss_valid_ff;
      iss_port_in  = iss_port_ff;
      if (start) begin
         iss_valid_in = 1'b1;
         iss_port_in  = '0;
      end else if (iss_valid_ff && rd_adv) begin
         if (iss_last) begin
            iss_valid_in = 1'b0;
         end else begin
            iss_port_in = iss_port_ff + PORT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_valid_ff <= 1'b0;
         iss_port_ff  <= '0;
      end else begin
         iss_valid_ff <= iss_valid_in;
         iss_port_ff  <= iss_port_in;
      end
      if (start) begin
         iss_np_ff      <= clamp_count(cfg_ports_ff, USED_PORTS);
         iss_nl_ff      <= clamp_count(cfg_layers_ff, USED_LAYERS);
         iss_samples_ff <= in_samples;
      end
   end

   // weight banks, one per layer, addressed by port
   cweight_type wr_weight;
   cweight_type rd_weights [USED_LAYERS];

   assign wr_weight.re = WEIGHT_BITS'(req_weight_re);
   assign wr_weight.im = WEIGHT_BITS'(req_weight_im);

   for (genvar l = 0; l < USED_LAYERS; l++) begin : g_bank
      logic bank_wr;
      assign bank_wr = req_accept && (req_action == ACT_LOAD) && slot.valid &&
                       (slot.layer == LAYER_W'(l));
      lmp_ram #(
         .WIDTH  (WEIGHT_W),
         .DEPTH  (MAX_PORTS),
         .ADDR_W (RAM_ADDR_W)
      ) u_bank (
         .clock   (clock),
         .wr_en   (bank_wr),
         .wr_addr (slot.port),
         .wr_data (wr_weight),
         .rd_en   (rd_adv),
         .rd_addr (RAM_ADDR_W'(iss_port_ff)),
         .rd_data (rd_weights[l])
      );
   end

   // read stage, aligned with RAM output
   logic      rd_valid_ff, rd_valid_in;
   tag_type   rd_tag_ff;
   csamp_type rd_samples_ff [IN_LAYERS];

   assign rd_valid_in = rd_adv ? iss_valid_ff : rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_valid_in;
      end
      if (rd_adv) begin
         rd_tag_ff     <= '{last: iss_last, port: iss_port_ff, nl: iss_nl_ff};
         rd_samples_ff <= iss_samples_ff;
      end
   end

   lmp_mac u_mac (
      .clock          (clock),
      .reset          (reset),
      .rd_valid       (rd_valid_ff),
      .rd_tag         (rd_tag_ff),
      .rd_samples     (rd_samples_ff),
      .rd_weights     (rd_weights),
      .rd_adv         (rd_adv),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_port_index (rsp_port_index),
      .rsp_port_re    (rsp_port_re),
      .rsp_port_im    (rsp_port_im),
      .rsp_last_port  (rsp_last_port)
   );

   a_port_bound: assert property (@(posedge clock) disable iff (reset)
      iss_valid_ff |-> (CNT_W'(iss_port_ff) < iss_np_ff))
      else $error("port counter ran past the port count");

   a_start_port0: assert property (@(posedge clock) disable iff (reset)
      start |=> (iss_valid_ff && iss_port_ff == '0))
      else $error("sample beat did not start at port zero");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (iss_valid_ff && iss_last && rd_adv && !start) |=> !iss_valid_ff)
      else $error("sequencer stayed busy after its last port");

endmodule
